// ===== sv/kdpc_pkg.sv =====
// Shared types and constants for the key debounce and press classifier.
`timescale 1ns / 1ps
`default_nettype none
package kdpc_pkg;

  localparam int unsigned MASK_W   = 4;
  localparam int unsigned KEY_W    = 2;
  localparam int unsigned SCAN_W   = 10;
  localparam int unsigned HELD_W   = 16;
  localparam int unsigned DEB_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [HELD_W-1:0] HELD_CAP = 16'd60000;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 10'd10;
  localparam logic [HELD_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 4'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd2;

  // Item action codes
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_period_ms;
    logic [HELD_W-1:0] long_press_ms;
    logic [DEB_W-1:0]  debounce_scans;
  } kdpc_cfg_t;

  typedef struct packed {
    logic is_long;
    logic [KEY_W-1:0] key;
  } kdpc_event_t;

  typedef struct packed {
    logic stable_next;
    logic release_evt;
    logic long_evt;
  } kdpc_key_stat_t;

endpackage
`default_nettype wire

// ===== sv/kdpc_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface kdpc_cmd_if;
  import kdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [MASK_W-1:0] raw_mask;

  modport source (output valid, output action, output raw_mask, input ready);
  modport sink   (input valid, input action, input raw_mask, output ready);
endinterface

interface kdpc_res_if;
  import kdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              event_present;
  logic [KEY_W-1:0]  event_key;
  logic              event_is_long;
  logic [MASK_W-1:0] pressed_mask;

  modport source (output valid, output event_present, output event_key,
                  output event_is_long, output pressed_mask, input ready);
  modport sink   (input valid, input event_present, input event_key,
                  input event_is_long, input pressed_mask, output ready);
endinterface
`default_nettype wire

// ===== sv/kdpc_key.sv =====
// Per-key debouncer, held-time counter and short/long press detection.
`timescale 1ns / 1ps
`default_nettype none
module kdpc_key (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                scan_go,
  input  wire logic                raw,
  input  wire kdpc_pkg::kdpc_cfg_t cfg,
  output kdpc_pkg::kdpc_key_stat_t stat
);
  import kdpc_pkg::*;

  logic              stable;
  logic [DEB_W-1:0]  count;
  logic [HELD_W-1:0] held;
  logic              long_done;

  logic              stable_next;
  logic [DEB_W-1:0]  count_next;
  logic [HELD_W-1:0] held_next;
  logic              long_done_next;
  logic              release_evt;
  logic              long_evt;
  logic [DEB_W-1:0]  count_inc;
  logic [HELD_W-1:0] held_mid;

  always_comb begin
    stable_next    = stable;
    count_next     = count;
    held_mid       = held;
    long_done_next = long_done;
    release_evt    = 1'b0;
    long_evt       = 1'b0;
    count_inc      = (count < cfg.debounce_scans) ? count + 1'b1 : count;
    held_next      = held;

    if (scan_go) begin
      if (raw == stable) begin
        count_next = '0;
      end else if (count_inc < cfg.debounce_scans) begin
        count_next = count_inc;
      end else begin
        count_next  = '0;
        stable_next = raw;
        held_mid    = '0;
        if (raw) begin
          long_done_next = 1'b0;
        end else begin
          // a release after a long event, or with no held time, is silent
          release_evt = !long_done && (held != '0);
        end
      end

      held_next = held_mid;
      if (stable_next) begin
        if (held_mid < HELD_CAP) begin
          held_next = held_mid + HELD_W'(cfg.scan_period_ms);
        end
        if (!long_done_next && (held_next >= cfg.long_press_ms)) begin
          long_done_next = 1'b1;
          long_evt       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= 1'b0;
      count     <= '0;
      held      <= '0;
      long_done <= 1'b0;
    end else begin
      stable    <= stable_next;
      count     <= count_next;
      held      <= held_next;
      long_done <= long_done_next;
    end
  end

  assign stat.stable_next = stable_next;
  assign stat.release_evt = release_evt;
  assign stat.long_evt    = long_evt;

endmodule
`default_nettype wire

// ===== sv/key_debounce_press_classifier_unit.sv =====
// Key debouncer with short/long press classification and an event ring.
// Channels: cmd (sink) carries action and raw_mask; action scan feeds the
// raw key levels to the debouncers, action take pops the oldest event.
// result (source) returns exactly one item per command: the popped event
// (or none) and the debounced pressed mask after the command.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write scan period, long
// press threshold and debounce count; write only while the block is idle.
// Latency: the result is valid the cycle after the command transfer.
// Throughput: one command per cycle; all keys are updated in parallel and
// the event ring takes up to one event per key in the same cycle.
// The result sits in an output register; a new command is taken whenever
// that register is empty or being drained, so a stall on result holds cmd
// off only while a result is still waiting.
// The ring holds RING_DEPTH-1 events; further events are dropped.
// Reset clears all key state, the ring pointers and the configuration to
// its defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_press_classifier_unit #(
  parameter int unsigned NUM_KEYS   = 4,
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  kdpc_cmd_if.sink                               cmd,
  kdpc_res_if.source                             result,
  input  wire logic                              cfg_wr_en,
  input  wire logic [kdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kdpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kdpc_pkg::*;

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned NUM_EV = 2 * NUM_KEYS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  kdpc_cfg_t cfg;

  logic [PTR_W-1:0] wr_pos;
  logic [PTR_W-1:0] rd_pos;
  logic [PTR_W-1:0] wr_pos_next;
  logic [PTR_W-1:0] rd_pos_next;
  kdpc_event_t      ring [RING_DEPTH];

  logic              res_valid;
  logic              res_present;
  logic [KEY_W-1:0]  res_key;
  logic              res_long;
  logic [MASK_W-1:0] res_mask;

  logic cmd_go;
  logic scan_go;
  logic take_go;
  logic ring_has;

  kdpc_key_stat_t    stat [NUM_KEYS];
  logic [MASK_W-1:0] mask_next;

  logic              ev_cand  [NUM_EV];
  kdpc_event_t       ev_code  [NUM_EV];
  logic              ev_wr    [NUM_EV];
  logic [PTR_W-1:0]  ev_pos   [NUM_EV];

  assign cmd.ready = !res_valid || result.ready;
  assign cmd_go    = cmd.valid && cmd.ready;
  assign scan_go   = cmd_go && (cmd.action == ACT_SCAN);
  assign take_go   = cmd_go && (cmd.action == ACT_TAKE);
  assign ring_has  = (rd_pos != wr_pos);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period_ms <= SCAN_PERIOD_RST;
      cfg.long_press_ms  <= LONG_PRESS_RST;
      cfg.debounce_scans <= DEBOUNCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCAN_PERIOD: cfg.scan_period_ms <= cfg_wdata[SCAN_W-1:0];
        CFG_LONG_PRESS:  cfg.long_press_ms  <= cfg_wdata[HELD_W-1:0];
        CFG_DEBOUNCE:    cfg.debounce_scans <= cfg_wdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdpc_key u_key (
      .clk     (clk),
      .rst     (rst),
      .scan_go (scan_go),
      .raw     (cmd.raw_mask[k]),
      .cfg     (cfg),
      .stat    (stat[k])
    );
  end

  always_comb begin
    mask_next = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      mask_next[k] = stat[k].stable_next;
    end
  end

  // Releases first in key order, then long presses in key order
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      ev_cand[k]                  = stat[k].release_evt;
      ev_code[k].is_long          = 1'b0;
      ev_code[k].key              = KEY_W'(k);
      ev_cand[NUM_KEYS + k]         = stat[k].long_evt;
      ev_code[NUM_KEYS + k].is_long = 1'b1;
      ev_code[NUM_KEYS + k].key     = KEY_W'(k);
    end
  end

  always_comb begin
    wr_pos_next = wr_pos;
    for (int j = 0; j < NUM_EV; j++) begin
      ev_pos[j] = wr_pos_next;
      ev_wr[j]  = 1'b0;
      if (ev_cand[j] && (ptr_inc(wr_pos_next) != rd_pos)) begin
        ev_wr[j]    = 1'b1;
        wr_pos_next = ptr_inc(wr_pos_next);
      end
    end
  end

  assign rd_pos_next = (take_go && ring_has) ? ptr_inc(rd_pos) : rd_pos;

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_EV; j++) begin
      if (ev_wr[j]) begin
        ring[ev_pos[j]] <= ev_code[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      rd_pos <= '0;
    end else begin
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_go) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_go) begin
      res_mask <= mask_next;
      if (take_go && ring_has) begin
        res_present <= 1'b1;
        res_key     <= ring[rd_pos].key;
        res_long    <= ring[rd_pos].is_long;
      end else begin
        res_present <= 1'b0;
        res_key     <= '0;
        res_long    <= 1'b0;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.event_present = res_present;
  assign result.event_key     = res_key;
  assign result.event_is_long = res_long;
  assign result.pressed_mask  = res_mask;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_go |=> res_valid)
    else $error("accepted command produced no result");

  a_no_event_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_present) |-> (res_key == '0 && !res_long))
    else $error("empty result carries event fields");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (wr_pos <= PTR_LAST) && (rd_pos <= PTR_LAST))
    else $error("ring pointer out of range");

  a_scan_no_event: assert property (@(posedge clk) disable iff (rst)
    (cmd_go && cmd.action == ACT_SCAN) |=> !res_present)
    else $error("scan returned an event");

  a_ring_not_overrun: assert property (@(posedge clk) disable iff (rst)
    (wr_pos_next != wr_pos) |-> (wr_pos_next != rd_pos))
    else $error("ring write caught up with read pointer");

endmodule
`default_nettype wire
